// ===== rtl/core/sact_pkg.sv =====
// Shared types, codes and helpers of the set-associative cache tag controller.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package sact_pkg;

  // Default geometry
  localparam int unsigned DEF_WAYS            = 4;
  localparam int unsigned DEF_SETS            = 64;
  localparam int unsigned DEF_LINE_BYTES_LOG2 = 5;
  localparam int unsigned DEF_QUEUE_DEPTH     = 2;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LFSR_W    = 8;

  // Request opcodes
  localparam logic [1:0] OP_ACCESS     = 2'd0;
  localparam logic [1:0] OP_REFILL     = 2'd1;
  localparam logic [1:0] OP_FLUSH_ALL  = 2'd2;
  localparam logic [1:0] OP_FLUSH_LINE = 2'd3;

  // Response status codes
  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_RETRY      = 3'd2;
  localparam logic [2:0] ST_BYPASS     = 3'd3;
  localparam logic [2:0] ST_INSTALLED  = 3'd4;
  localparam logic [2:0] ST_FLUSH_ACK  = 3'd5;
  localparam logic [2:0] ST_LINE_INVAL = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  typedef struct packed {
    logic              enable;
    logic [2:0]        shift;
    logic [ADDR_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        hit_way;
    logic [ADDR_W-1:0] downstream_addr;
  } rsp_t;

  // Map an address into the downstream address space (32-bit wrap)
  function automatic logic [ADDR_W-1:0] to_downstream(logic [ADDR_W-1:0] a, cfg_t c);
    return (a << c.shift) + c.offset;
  endfunction

  // Victim LFSR step: inverted XOR of bits 7,3,2,1 enters at bit 0
  function automatic logic [LFSR_W-1:0] lfsr_step(logic [LFSR_W-1:0] s);
    return {s[6:0], ~(s[7] ^ s[3] ^ s[2] ^ s[1])};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sact_chan_if.sv =====
// Valid/ready channel carrying one request or response payload.
// The payload type is set per instance; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sact_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sact_front.sv =====
// Front end: accepts requests, splits the address into line tag and set index,
// and maps the downstream address. Uses sact_pkg and sact_chan_if.
`timescale 1ns / 1ps
`default_nettype none

module sact_front #(
  parameter int unsigned SETS            = 64,
  parameter int unsigned LINE_BYTES_LOG2 = 5,
  parameter int unsigned TAGW            = 27,
  parameter int unsigned SETW            = 6,
  parameter type         item_t          = logic
) (
  input  logic          clk,
  input  logic          rst,
  input  sact_pkg::cfg_t cfg,
  input  logic          clearing,
  sact_chan_if.sink     req,
  output logic          push,
  output item_t         push_item,
  input  logic          push_ready
);
  import sact_pkg::*;

  // Set index = tag mod SETS via exact reciprocal: q = (tag * RECIP) >> K
  localparam int unsigned L2 = $clog2(SETS);
  localparam int unsigned K  = TAGW + L2;
  localparam int unsigned MW = TAGW + 1;
  localparam int unsigned PW = TAGW + MW;
  localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [MW-1:0]   RECIP  = RECIP64[MW-1:0];
  localparam logic [TAGW-1:0] SETS_T = TAGW'(SETS);

  logic              take;
  logic [TAGW-1:0]   in_tag;
  logic [ADDR_W-1:0] in_line_addr;
  logic [ADDR_W-1:0] in_ds_addr;

  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [TAGW-1:0]   s1_tag;
  logic [PW-1:0]     s1_prod;
  logic [ADDR_W-1:0] s1_ds_addr;

  logic [PW-1:0]     prod_shifted;
  logic [TAGW-1:0]   quot;
  logic [TAGW-1:0]   rem;

  // Accept when the stage is free or drains into the queue, never while clearing
  assign req.ready = (!s1_valid || push_ready) && !clearing;
  assign take      = req.valid && req.ready;

  assign in_tag       = req.payload.address[ADDR_W-1:LINE_BYTES_LOG2];
  assign in_line_addr = {in_tag, {LINE_BYTES_LOG2{1'b0}}};
  assign in_ds_addr   = to_downstream(cfg.enable ? in_line_addr : req.payload.address, cfg);

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage payload, reciprocal product registered
  always_ff @(posedge clk) begin
    if (take) begin
      s1_op      <= req.payload.opcode;
      s1_tag     <= in_tag;
      s1_prod    <= {{MW{1'b0}}, in_tag} * {{TAGW{1'b0}}, RECIP};
      s1_ds_addr <= in_ds_addr;
    end
  end

  // Finish the remainder and hand the item to the queue
  assign prod_shifted = s1_prod >> K;
  assign quot         = prod_shifted[TAGW-1:0];
  assign rem          = s1_tag - quot * SETS_T;

  assign push                = s1_valid;
  assign push_item.op        = s1_op;
  assign push_item.tag       = s1_tag;
  assign push_item.set_idx   = rem[SETW-1:0];
  assign push_item.ds_addr   = s1_ds_addr;

endmodule

`default_nettype wire

// ===== rtl/core/sact_queue.sv =====
// Short FIFO between the front end and the tag directory back end.
// Generic over the item type; uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module sact_queue #(
  parameter int unsigned DEPTH  = 2,
  parameter type         item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  input  logic  pop,
  output item_t pop_item,
  output logic  pop_valid
);
  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam logic [PTRW-1:0] LAST_SLOT = PTRW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(DEPTH);

  item_t           slots [DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sact_back.sv =====
// Back end: tag directory memory, hit/miss decision, victim LFSR, refill
// tracking, flush sweeps and the response register. Uses sact_pkg, sact_chan_if.
`timescale 1ns / 1ps
`default_nettype none

module sact_back #(
  parameter int unsigned WAYS   = 4,
  parameter int unsigned SETS   = 64,
  parameter int unsigned TAGW   = 27,
  parameter int unsigned SETW   = 6,
  parameter int unsigned WAYW   = 2,
  parameter type         item_t = logic
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cache_enable,
  input  logic       pop_valid,
  input  item_t      pop_item,
  output logic       pop,
  output logic       clearing,
  sact_chan_if.source rsp
);
  import sact_pkg::*;

  localparam logic [SETW-1:0] LAST_SET = SETW'(SETS - 1);
  localparam logic [WAYW-1:0] WAY_MASK = WAYW'(WAYS - 1);

  typedef struct packed {
    logic            valid;
    logic [TAGW-1:0] tag;
  } entry_t;
  typedef entry_t [WAYS-1:0] row_t;

  row_t mem [SETS];

  // Execute stage
  logic            e_valid;
  item_t           e_item;
  logic            e_fire;
  logic            advance;
  row_t            rd_row;
  row_t            eff_row;

  // Last write, for a read that raced it
  logic [WAYS-1:0] fwd_mask;
  logic [SETW-1:0] fwd_set;
  row_t            fwd_row;

  logic [WAYS-1:0] match;
  logic            hit;
  logic [WAYW-1:0] hit_w;
  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] lfsr_next;
  logic [WAYW-1:0] victim;

  logic            busy;
  logic [SETW-1:0] refill_set;
  logic [WAYW-1:0] fill_way;
  logic [TAGW-1:0] fill_tag;

  logic [SETW-1:0] sweep_idx;

  logic            do_miss;
  logic            start_sweep;
  logic [WAYS-1:0] e_wr_mask;
  logic [SETW-1:0] e_wr_set;
  row_t            e_wr_row;
  rsp_t            e_rsp;

  logic [WAYS-1:0] mem_mask;
  logic [SETW-1:0] mem_set;
  row_t            mem_row;

  logic            out_valid;
  rsp_t            out_rsp;

  assign e_fire  = e_valid && (!out_valid || rsp.ready);
  assign advance = !e_valid || e_fire;
  assign pop     = advance && pop_valid && !clearing &&
                   !(e_valid && e_item.op == OP_FLUSH_ALL);

  // Merge the write that landed as this row was read
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      eff_row[w] = (fwd_mask[w] && fwd_set == e_item.set_idx) ? fwd_row[w] : rd_row[w];
      match[w]   = eff_row[w].valid && (eff_row[w].tag == e_item.tag);
    end
  end

  // Lowest matching way
  always_comb begin
    hit   = |match;
    hit_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_w = WAYW'(w);
      end
    end
  end

  assign lfsr_next = lfsr_step(lfsr);
  assign victim    = lfsr_next[WAYW:1] & WAY_MASK;

  // Decide the outcome of the item in the execute stage
  always_comb begin
    do_miss     = 1'b0;
    start_sweep = 1'b0;
    e_wr_mask   = '0;
    e_wr_set    = e_item.set_idx;
    e_wr_row    = '0;
    e_rsp       = '0;
    case (e_item.op)
      OP_ACCESS: begin
        if (!cache_enable) begin
          e_rsp.status          = ST_BYPASS;
          e_rsp.downstream_addr = e_item.ds_addr;
        end else if (busy) begin
          e_rsp.status = ST_RETRY;
        end else if (hit) begin
          e_rsp.status  = ST_HIT;
          e_rsp.hit_way = 2'(hit_w);
        end else begin
          do_miss               = 1'b1;
          e_rsp.status          = ST_MISS;
          e_rsp.hit_way         = 2'(victim);
          e_rsp.downstream_addr = e_item.ds_addr;
        end
      end
      OP_REFILL: begin
        e_rsp.status = ST_INSTALLED;
        if (busy) begin
          e_rsp.hit_way = 2'(fill_way);
          e_wr_set      = refill_set;
          for (int w = 0; w < WAYS; w++) begin
            e_wr_mask[w]      = (WAYW'(w) == fill_way);
            e_wr_row[w].valid = 1'b1;
            e_wr_row[w].tag   = fill_tag;
          end
        end
      end
      OP_FLUSH_ALL: begin
        start_sweep  = 1'b1;
        e_rsp.status = ST_FLUSH_ACK;
      end
      OP_FLUSH_LINE: begin
        e_wr_mask    = match;
        e_rsp.status = ST_LINE_INVAL;
      end
      default: begin
        e_rsp.status = ST_FLUSH_ACK;
      end
    endcase
  end

  // Memory write port: sweep has priority, else the executing item
  assign mem_set  = clearing ? sweep_idx : e_wr_set;
  assign mem_mask = clearing ? {WAYS{1'b1}} : (e_fire ? e_wr_mask : '0);
  assign mem_row  = clearing ? '0 : e_wr_row;

  // Tag directory memory
  always_ff @(posedge clk) begin
    for (int w = 0; w < WAYS; w++) begin
      if (mem_mask[w]) begin
        mem[mem_set][w] <= mem_row[w];
      end
    end
    if (pop) begin
      rd_row <= mem[pop_item.set_idx];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      fwd_mask  <= '0;
      lfsr      <= '0;
      busy      <= 1'b0;
      clearing  <= 1'b1;
      sweep_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        e_valid  <= pop;
        fwd_mask <= e_fire ? e_wr_mask : '0;
      end
      // Walk all sets to invalidate
      if (clearing) begin
        if (sweep_idx == LAST_SET) begin
          clearing  <= 1'b0;
          sweep_idx <= '0;
        end else begin
          sweep_idx <= sweep_idx + 1'b1;
        end
      end else if (e_fire && start_sweep) begin
        clearing <= 1'b1;
      end
      if (e_fire && do_miss) begin
        lfsr <= lfsr_next;
        busy <= 1'b1;
      end else if (e_fire && e_item.op == OP_REFILL) begin
        busy <= 1'b0;
      end
      if (e_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      e_item <= pop_item;
    end
    if (advance) begin
      fwd_set <= e_wr_set;
      fwd_row <= e_wr_row;
    end
    if (e_fire && do_miss) begin
      refill_set <= e_item.set_idx;
      fill_way   <= victim;
      fill_tag   <= e_item.tag;
    end
    if (e_fire) begin
      out_rsp <= e_rsp;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_rsp;

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_cache_tag_controller.sv =====
// Top level of the set-associative cache tag controller: configuration
// registers, front end, queue and back end. Uses sact_pkg and sact_chan_if.
//
// Usage: requests (opcode, address) enter on req; each gives exactly one
// response (status, hit_way, downstream_addr) on rsp, in order. Both channels
// are valid/ready. Configuration is written through cfg_we/cfg_index/cfg_data
// while no request is outstanding; index 0 enable, 1 shift, 2 offset.
// Path: a request passes the front register, the queue, the directory read
// and the response register before its response is valid on rsp.
// Throughput: one request per cycle while rsp is ready and no flush walk
// runs. A flush-all stops the back end while it walks every set; after reset
// the same walk runs, and req.ready stays low during it. One refill is
// tracked at a time; accesses during it return a retry status while the
// cache is enabled. When rsp is stalled, the response register holds, the
// queue fills and req.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_controller #(
  parameter int unsigned WAYS            = sact_pkg::DEF_WAYS,
  parameter int unsigned SETS            = sact_pkg::DEF_SETS,
  parameter int unsigned LINE_BYTES_LOG2 = sact_pkg::DEF_LINE_BYTES_LOG2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sact_pkg::ADDR_W-1:0]     cfg_data,
  sact_chan_if.sink                       req,
  sact_chan_if.source                     rsp
);
  import sact_pkg::*;

  localparam int unsigned TAGW = ADDR_W - LINE_BYTES_LOG2;
  localparam int unsigned SETW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAYW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic [1:0]        op;
    logic [TAGW-1:0]   tag;
    logic [SETW-1:0]   set_idx;
    logic [ADDR_W-1:0] ds_addr;
  } item_t;

  cfg_t  cfg;
  logic  clearing;
  logic  push;
  item_t push_item;
  logic  push_ready;
  logic  pop;
  item_t pop_item;
  logic  pop_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b1;
      cfg.shift  <= '0;
      cfg.offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: cfg.enable <= cfg_data[0];
        CFG_SHIFT:  cfg.shift  <= cfg_data[2:0];
        CFG_OFFSET: cfg.offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sact_front #(
    .SETS            (SETS),
    .LINE_BYTES_LOG2 (LINE_BYTES_LOG2),
    .TAGW            (TAGW),
    .SETW            (SETW),
    .item_t          (item_t)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .req        (req),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  sact_queue #(
    .DEPTH  (DEF_QUEUE_DEPTH),
    .item_t (item_t)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid)
  );

  sact_back #(
    .WAYS   (WAYS),
    .SETS   (SETS),
    .TAGW   (TAGW),
    .SETW   (SETW),
    .WAYW   (WAYW),
    .item_t (item_t)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cache_enable (cfg.enable),
    .pop_valid    (pop_valid),
    .pop_item     (pop_item),
    .pop          (pop),
    .clearing     (clearing),
    .rsp          (rsp)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_set_assoc_cache_tag_controller.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of set_assoc_cache_tag_controller: lookups, refills
// and flushes under random stalls, checked against a directory predictor.
// Depends on sact_pkg, sact_chan_if and the RTL top level.

module tb_set_assoc_cache_tag_controller;
  import sact_pkg::*;

  localparam int unsigned WAYS         = DEF_WAYS;
  localparam int unsigned SETS         = DEF_SETS;
  localparam int unsigned LINE_LOG2    = DEF_LINE_BYTES_LOG2;
  localparam int unsigned ENTRIES      = WAYS * SETS;
  localparam int unsigned TAG_W        = ADDR_W - LINE_LOG2;
  localparam int unsigned SET_W        = $clog2(SETS);
  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned POOL_LINES   = 10;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned WALK_HOLDOFF = SETS + 16;
  localparam int unsigned LONG_HOLD    = 300;

  typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  sact_chan_if #(.payload_t(req_t)) req_if ();
  sact_chan_if #(.payload_t(rsp_t)) rsp_if ();

  set_assoc_cache_tag_controller #(
    .WAYS(WAYS),
    .SETS(SETS),
    .LINE_BYTES_LOG2(LINE_LOG2)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directory predictor state
  logic              dir_valid [ENTRIES];
  logic [TAG_W-1:0]  dir_tag   [ENTRIES];
  logic [LFSR_W-1:0] victim_lfsr;
  logic              refill_pending;
  int unsigned       refill_entry;
  logic [TAG_W-1:0]  pend_tag;
  cfg_t              cfg_shadow;

  req_t        req_backlog[$];
  rsp_t        expected_rsp_q[$];
  int unsigned pushed_count  = 0;
  int unsigned checked_count = 0;
  int unsigned errors        = 0;

  // Work out the response of one request and update the directory
  function automatic rsp_t predict_tag_lookup(req_t r);
    rsp_t              o;
    logic [TAG_W-1:0]  line;
    logic [ADDR_W-1:0] fwd;
    int unsigned       base;
    int unsigned       way;
    logic              hit;
    o    = '0;
    line = r.address[ADDR_W-1:LINE_LOG2];
    base = (line % SETS) * WAYS;
    fwd  = r.address;
    hit  = 1'b0;
    way  = 0;
    case (r.opcode)
      OP_ACCESS: begin
        if (!cfg_shadow.enable) begin
          o.status          = ST_BYPASS;
          o.downstream_addr = (fwd << cfg_shadow.shift) + cfg_shadow.offset;
        end else if (refill_pending) begin
          o.status = ST_RETRY;
        end else begin
          for (int i = 0; i < WAYS; i++) begin
            if (!hit && dir_valid[base + i] && dir_tag[base + i] == line) begin
              hit = 1'b1;
              way = i;
            end
          end
          if (hit) begin
            o.status = ST_HIT;
          end else begin
            // Step the victim LFSR and start the refill
            victim_lfsr = {victim_lfsr[LFSR_W-2:0],
                           ~(victim_lfsr[7] ^ victim_lfsr[3] ^ victim_lfsr[2] ^ victim_lfsr[1])};
            way = ((victim_lfsr >> 1) & (WAYS - 1)) % WAYS;
            refill_pending = 1'b1;
            refill_entry   = base + way;
            pend_tag       = line;
            fwd[LINE_LOG2-1:0] = '0;
            o.status          = ST_MISS;
            o.downstream_addr = (fwd << cfg_shadow.shift) + cfg_shadow.offset;
          end
          o.hit_way = way[1:0];
        end
      end
      OP_REFILL: begin
        o.status = ST_INSTALLED;
        if (refill_pending && refill_entry < ENTRIES) begin
          dir_valid[refill_entry] = 1'b1;
          dir_tag[refill_entry]   = pend_tag;
          way       = refill_entry % WAYS;
          o.hit_way = way[1:0];
        end
        refill_pending = 1'b0;
      end
      OP_FLUSH_ALL: begin
        for (int i = 0; i < ENTRIES; i++) dir_valid[i] = 1'b0;
        o.status = ST_FLUSH_ACK;
      end
      default: begin
        for (int i = 0; i < WAYS; i++) begin
          if (dir_valid[base + i] && dir_tag[base + i] == line) dir_valid[base + i] = 1'b0;
        end
        o.status = ST_LINE_INVAL;
      end
    endcase
    return o;
  endfunction

  task automatic push_req(logic [1:0] op, logic [ADDR_W-1:0] addr);
    req_t r;
    r.opcode  = op;
    r.address = addr;
    req_backlog.insert(req_backlog.size(), r);
    pushed_count++;
  endtask

  // Wait until every request has its response, then let the block settle
  task automatic wait_drained(int unsigned settle);
    while (checked_count != pushed_count) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write all three registers, one per cycle, and mirror them
  task automatic write_cfg(logic en, logic [2:0] sh, logic [ADDR_W-1:0] off);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= {{(ADDR_W-1){1'b0}}, en};
    @(posedge clk);
    cfg_index <= CFG_SHIFT;
    cfg_data  <= {{(ADDR_W-3){1'b0}}, sh};
    @(posedge clk);
    cfg_index <= CFG_OFFSET;
    cfg_data  <= off;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow.enable = en;
    cfg_shadow.shift  = sh;
    cfg_shadow.offset = off;
  endtask

  // Request driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.insert(expected_rsp_q.size(), predict_tag_lookup(req_if.payload));
      end
      if (req_if.valid && !req_if.ready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        req_if.valid   <= 1'b1;
        req_if.payload <= req_backlog.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response monitor and receiver stall pattern
  rsp_t        oldest_rsp;
  rx_mode_t    rx_mode      = RX_FREE;
  int unsigned mode_left    = 0;
  int unsigned toggle_count = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response with none expected: status %0d way %0d addr %h", $time,
                   rsp_if.payload.status, rsp_if.payload.hit_way, rsp_if.payload.downstream_addr);
          errors++;
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          if (rsp_if.payload.status !== oldest_rsp.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     oldest_rsp.status, rsp_if.payload.status);
            errors++;
          end
          if (rsp_if.payload.hit_way !== oldest_rsp.hit_way) begin
            $display("%0t: hit_way mismatch: expected %0d, actual %0d", $time,
                     oldest_rsp.hit_way, rsp_if.payload.hit_way);
            errors++;
          end
          if (rsp_if.payload.downstream_addr !== oldest_rsp.downstream_addr) begin
            $display("%0t: downstream_addr mismatch: expected %h, actual %h", $time,
                     oldest_rsp.downstream_addr, rsp_if.payload.downstream_addr);
            errors++;
          end
          checked_count++;
        end
      end
      // Hold off once for a long stretch while requests keep coming
      if (!hold_done && checked_count >= 300 && req_backlog.size() > 16) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        toggle_count++;
        case (rx_mode)
          RX_FREE:   rsp_if.ready <= 1'b1;
          RX_MOSTLY: rsp_if.ready <= ($urandom_range(0, 9) < 7);
          RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 9) < 3);
          default:   rsp_if.ready <= toggle_count[0];
        endcase
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d responses outstanding", $time,
             pushed_count - checked_count);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus: directed requests, then random phases under several settings
  initial begin : stimulus
    logic [ADDR_W-1:0] pool [POOL_LINES];
    logic [SET_W-1:0]  hot_set [2];
    logic [ADDR_W-1:0] addr;
    int unsigned       phase_start;
    int unsigned       pick;
    logic              en;
    logic [2:0]        sh;
    logic [ADDR_W-1:0] off;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ENABLE;
    cfg_data     = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_tag[i]   = '0;
    end
    victim_lfsr       = '0;
    refill_pending    = 1'b0;
    refill_entry      = 0;
    pend_tag          = '0;
    cfg_shadow.enable = 1'b1;
    cfg_shadow.shift  = '0;
    cfg_shadow.offset = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: miss, retry, flushes while busy, install, hits
    push_req(OP_ACCESS, 32'h0000_0000);
    push_req(OP_ACCESS, 32'h0000_0004);
    push_req(OP_FLUSH_LINE, 32'h0000_0000);
    push_req(OP_FLUSH_ALL, 32'h0000_0000);
    push_req(OP_REFILL, 32'h0000_0000);
    push_req(OP_ACCESS, 32'h0000_001F);
    push_req(OP_REFILL, 32'hFFFF_FFFF);
    push_req(OP_ACCESS, 32'hFFFF_FFFF);
    push_req(OP_REFILL, 32'h0000_0000);
    push_req(OP_ACCESS, 32'hFFFF_FFE0);
    push_req(OP_FLUSH_LINE, 32'hFFFF_FFFF);
    push_req(OP_ACCESS, 32'hFFFF_FFFF);
    push_req(OP_REFILL, 32'h0000_0000);
    // Overfill set 0 to force evictions
    for (int k = 1; k <= 4; k++) begin
      push_req(OP_ACCESS, k << 11);
      push_req(OP_REFILL, 32'h0000_0000);
    end
    // Leave a refill in flight across the settings change
    push_req(OP_ACCESS, 32'h0001_2340);
    wait_drained(WALK_HOLDOFF);

    // Disabled with extreme shift and offset: bypass while busy, then complete
    write_cfg(1'b0, 3'd7, 32'hFFFF_FFFF);
    push_req(OP_ACCESS, 32'hFFFF_FFFF);
    push_req(OP_ACCESS, 32'h0000_0000);
    push_req(OP_FLUSH_LINE, 32'h0000_0800);
    push_req(OP_REFILL, 32'h0000_0000);
    push_req(OP_FLUSH_ALL, 32'h0000_0000);
    wait_drained(WALK_HOLDOFF);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin en = 1'b1; sh = 3'd0; off = 32'h0000_0000; end
        1:       begin en = 1'b1; sh = 3'd7; off = 32'hFFFF_FFFF; end
        2:       begin en = 1'b0; sh = 3'($urandom_range(0, 7)); off = $urandom(); end
        3:       begin en = 1'b1; sh = 3'($urandom_range(0, 7)); off = $urandom(); end
        default: begin en = 1'b1; sh = 3'($urandom_range(1, 6)); off = 32'h0000_0000; end
      endcase
      write_cfg(en, sh, off);

      // Build a pool of lines crowded into two sets so that ways get evicted
      hot_set[0] = SET_W'($urandom_range(0, SETS - 1));
      hot_set[1] = SET_W'($urandom_range(0, SETS - 1));
      for (int j = 0; j < POOL_LINES; j++) begin
        addr = $urandom();
        addr[LINE_LOG2 +: SET_W] = hot_set[j % 2];
        addr[LINE_LOG2-1:0]      = '0;
        pool[j] = addr;
      end

      phase_start = pushed_count;
      while (pushed_count - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        addr = pool[$urandom_range(0, POOL_LINES - 1)] | $urandom_range(0, (1 << LINE_LOG2) - 1);
        if (pick < 50) begin
          // well-formed lookup followed by its refill completion
          push_req(OP_ACCESS, addr);
          push_req(OP_REFILL, $urandom());
        end else if (pick < 70) begin
          push_req(OP_ACCESS, addr);
        end else if (pick < 80) begin
          push_req(OP_ACCESS, $urandom());
        end else if (pick < 88) begin
          push_req(OP_REFILL, $urandom());
        end else if (pick < 94) begin
          push_req(OP_FLUSH_LINE, addr);
        end else if (pick < 97) begin
          push_req(OP_FLUSH_LINE, $urandom());
        end else begin
          push_req(OP_FLUSH_ALL, $urandom());
        end
      end
      // Pause the sender until every response is back
      wait_drained(WALK_HOLDOFF);
    end

    wait_drained(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
